FILE: hw/rtl/key_based_mutex_node_macros.svh
// Assertion macros shared by the mutual exclusion node RTL.
// Needs a clk_i clock and an active-low rst_ni reset in the including scope.
`ifndef KEY_BASED_MUTEX_NODE_MACROS_SVH
`define KEY_BASED_MUTEX_NODE_MACROS_SVH
`ifndef SYNTHESIS
`define KMX_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define KMX_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define KMX_ASSERT_IMP(lbl, ante, cons, msg)
`define KMX_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

FILE: hw/rtl/kmx_pkg.sv
// Types and constants of the key-per-neighbor mutual exclusion node.
// Used by the controller, the datapath and the top level.
`timescale 1ns / 1ps

package kmx_pkg;

  localparam int unsigned FUNC_W    = 2;
  localparam int unsigned ID_W      = 4;
  localparam int unsigned TIME_W    = 16;
  localparam int unsigned MASK_W    = 16;
  localparam int unsigned NUM_IDS   = 16;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [TIME_W-1:0] TIME_MAX = '1;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_LOCAL = 2'd0,
    FUNC_REQ   = 2'd1,
    FUNC_KEY   = 2'd2
  } func_e;

  typedef enum logic [1:0] {
    KIND_REQ   = 2'd0,
    KIND_KEY   = 2'd1,
    KIND_ENTER = 2'd2
  } kind_e;

  localparam logic [CFG_IDX_W-1:0] REG_OWN_ID   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_NBR_MASK = 1'b1;

  // At most one step command per cycle from the controller; none while go is low.
  typedef struct packed {
    logic start;
    logic lscan;
    logic msg;
    logic rereq;
    logic enter;
    logic dscan;
    logic flush;
  } cmd_t;

  typedef struct packed {
    logic requesting;
    logic all_keys;
    logic sid_nbr;
    logic sid_key;
    logic wins;
    logic cnt_last;
    logic go;
    logic hold_v;
  } sts_t;

endpackage

FILE: hw/rtl/kmx_ctrl.sv
// Sequencer of the mutual exclusion node: walks one input beat through its steps.
// Depends on kmx_pkg for the command and status structs.
`timescale 1ns / 1ps

module kmx_ctrl (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  input  logic [kmx_pkg::FUNC_W-1:0]      in_func_i,
  output logic                            in_ready_o,
  input  kmx_pkg::sts_t                   sts_i,
  output kmx_pkg::cmd_t                   cmd_o
);
  import kmx_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_LSCAN = 8'b0000_0010,
    S_MSG   = 8'b0000_0100,
    S_REREQ = 8'b0000_1000,
    S_TRY   = 8'b0001_0000,
    S_ENTER = 8'b0010_0000,
    S_DSCAN = 8'b0100_0000,
    S_FLUSH = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;
  logic   func_local, func_msg;

  // The kind of a received message is remembered here for the step after MSG.
  logic   key_beat_q;

  assign func_local = (in_func_i == FUNC_LOCAL);
  assign func_msg   = (in_func_i == FUNC_REQ) || (in_func_i == FUNC_KEY);
  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          if (func_local && !sts_i.requesting) begin
            state_d = S_LSCAN;
          end else if (func_msg) begin
            state_d = S_MSG;
          end else begin
            state_d = S_FLUSH;
          end
        end
      end
      S_LSCAN: begin
        if (sts_i.go) begin
          cmd_o.lscan = 1'b1;
          if (sts_i.cnt_last) begin
            state_d = S_TRY;
          end
        end
      end
      S_MSG: begin
        if (sts_i.go) begin
          cmd_o.msg = 1'b1;
          if (!sts_i.sid_nbr) begin
            state_d = S_FLUSH;
          end else if (key_beat_q) begin
            state_d = S_TRY;
          end else if (sts_i.requesting && sts_i.wins && sts_i.sid_key) begin
            state_d = S_REREQ;
          end else begin
            state_d = S_FLUSH;
          end
        end
      end
      S_REREQ: begin
        if (sts_i.go) begin
          cmd_o.rereq = 1'b1;
          state_d     = S_FLUSH;
        end
      end
      S_TRY: begin
        if (sts_i.requesting && sts_i.all_keys) begin
          state_d = S_ENTER;
        end else begin
          state_d = S_FLUSH;
        end
      end
      S_ENTER: begin
        if (sts_i.go) begin
          cmd_o.enter = 1'b1;
          state_d     = S_DSCAN;
        end
      end
      S_DSCAN: begin
        if (sts_i.go) begin
          cmd_o.dscan = 1'b1;
          if (sts_i.cnt_last) begin
            state_d = S_FLUSH;
          end
        end
      end
      S_FLUSH: begin
        if (sts_i.go) begin
          cmd_o.flush = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      key_beat_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cmd_o.start) begin
        key_beat_q <= (in_func_i == FUNC_KEY);
      end
    end
  end

endmodule

FILE: hw/rtl/kmx_datapath.sv
// Datapath of the mutual exclusion node: key and deferred bits, Lamport clock,
// neighbor scan counter, result holding stage and output register. Uses kmx_pkg.
`timescale 1ns / 1ps

module kmx_datapath #(
  parameter int unsigned MAX_NODES = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [kmx_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [kmx_pkg::MASK_W-1:0]      cfg_data_i,
  input  logic [kmx_pkg::FUNC_W-1:0]      in_func_i,
  input  logic [kmx_pkg::ID_W-1:0]        in_sid_i,
  input  logic [kmx_pkg::TIME_W-1:0]      in_time_i,
  input  kmx_pkg::cmd_t                   cmd_i,
  output kmx_pkg::sts_t                   sts_o,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [1:0]                      out_kind_o,
  output logic [kmx_pkg::ID_W-1:0]        out_dest_o,
  output logic [kmx_pkg::TIME_W-1:0]      out_stamp_o,
  output logic                            out_last_o
);
  import kmx_pkg::*;

  localparam int unsigned CNT_W = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAX_NODES - 1);

  function automatic logic [MAX_NODES-1:0] keys_for(input logic [ID_W-1:0] own);
    logic [MAX_NODES-1:0] k;
    for (int j = 0; j < MAX_NODES; j++) begin
      k[j] = (int'(own) < j);
    end
    return k;
  endfunction

  logic [ID_W-1:0]      own_id_q;
  logic [MASK_W-1:0]    mask_q;
  logic [MAX_NODES-1:0] key_q, key_d, def_q, def_d, nbr, sid_oh;
  logic [TIME_W-1:0]    clock_q, clock_d, pend_q, pend_d, sat_inc;
  logic                 req_q, req_d, bump_q, bump_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;

  logic [FUNC_W-1:0]    func_q;
  logic [ID_W-1:0]      sid_q;
  logic [TIME_W-1:0]    ts_q;

  logic                 hold_v_q, hold_v_d;
  logic [1:0]           hold_kind_q, hold_kind_d;
  logic [ID_W-1:0]      hold_dest_q, hold_dest_d;
  logic [TIME_W-1:0]    hold_stamp_q, hold_stamp_d;

  logic                 out_v_q, out_v_d, out_last_q, out_last_d;
  logic [1:0]           out_kind_q, out_kind_d;
  logic [ID_W-1:0]      out_dest_q, out_dest_d;
  logic [TIME_W-1:0]    out_stamp_q, out_stamp_d;

  logic                 emit, out_free, go, wins;
  logic [1:0]           e_kind;
  logic [ID_W-1:0]      e_dest;

  // A node is never its own neighbor; ids beyond the 4-bit range never are.
  always_comb begin
    for (int j = 0; j < MAX_NODES; j++) begin
      nbr[j]    = 1'b0;
      sid_oh[j] = 1'b0;
      if (j < NUM_IDS) begin
        nbr[j]    = mask_q[ID_W'(j)] && (own_id_q != ID_W'(j));
        sid_oh[j] = (sid_q == ID_W'(j));
      end
    end
  end

  assign sat_inc  = (clock_q == TIME_MAX) ? clock_q : clock_q + TIME_W'(1);
  assign wins     = (ts_q < pend_q) || ((ts_q == pend_q) && (sid_q < own_id_q));
  assign out_free = !out_v_q || out_ready_i;
  assign go       = !hold_v_q || out_free;

  assign sts_o.requesting = req_q;
  assign sts_o.all_keys   = &(key_q | ~nbr);
  assign sts_o.sid_nbr    = |(nbr & sid_oh);
  assign sts_o.sid_key    = |(key_q & sid_oh);
  assign sts_o.wins       = wins;
  assign sts_o.cnt_last   = (cnt_q == CNT_LAST);
  assign sts_o.go         = go;
  assign sts_o.hold_v     = hold_v_q;

  always_comb begin
    key_d   = key_q;
    def_d   = def_q;
    clock_d = clock_q;
    pend_d  = pend_q;
    req_d   = req_q;
    bump_d  = bump_q;
    cnt_d   = cnt_q;
    emit    = 1'b0;
    e_kind  = KIND_REQ;
    e_dest  = '0;

    if (cmd_i.start) begin
      cnt_d = '0;
      if ((in_func_i == FUNC_REQ) || (in_func_i == FUNC_KEY)) begin
        clock_d = (sat_inc > in_time_i) ? sat_inc : in_time_i;
      end else if ((in_func_i == FUNC_LOCAL) && !req_q) begin
        req_d  = 1'b1;
        pend_d = clock_q;
        bump_d = 1'b1;
      end
    end

    if (cmd_i.lscan) begin
      if (nbr[cnt_q] && !key_q[cnt_q]) begin
        emit   = 1'b1;
        e_kind = KIND_REQ;
        e_dest = ID_W'(cnt_q);
      end
      cnt_d = cnt_q + CNT_W'(1);
    end

    if (cmd_i.msg && sts_o.sid_nbr) begin
      if (func_q == FUNC_REQ) begin
        if (sts_o.sid_key && (!req_q || wins)) begin
          key_d  = key_q & ~sid_oh;
          emit   = 1'b1;
          e_kind = KIND_KEY;
          e_dest = sid_q;
        end else if (req_q && !wins) begin
          def_d = def_q | sid_oh;
        end
      end else begin
        key_d = key_q | sid_oh;
      end
    end

    if (cmd_i.rereq) begin
      emit   = 1'b1;
      e_kind = KIND_REQ;
      e_dest = sid_q;
    end

    if (cmd_i.enter) begin
      emit   = 1'b1;
      e_kind = KIND_ENTER;
      req_d  = 1'b0;
      cnt_d  = '0;
    end

    // Leaving: every deferred bit is cleared, and each deferred neighbor gets its key if it is held.
    if (cmd_i.dscan) begin
      if (def_q[cnt_q]) begin
        def_d[cnt_q] = 1'b0;
        if (nbr[cnt_q] && key_q[cnt_q]) begin
          key_d[cnt_q] = 1'b0;
          emit         = 1'b1;
          e_kind       = KIND_KEY;
          e_dest       = ID_W'(cnt_q);
        end
      end
      cnt_d = cnt_q + CNT_W'(1);
    end

    if (cmd_i.flush && bump_q) begin
      clock_d = sat_inc;
      bump_d  = 1'b0;
    end

    if (cfg_we_i) begin
      key_d = keys_for((cfg_idx_i == REG_OWN_ID) ? cfg_data_i[ID_W-1:0] : own_id_q);
      def_d = '0;
    end
  end

  // The newest result waits in the holding stage until it is known whether
  // it closes the beat's results.
  always_comb begin
    hold_v_d     = hold_v_q;
    hold_kind_d  = hold_kind_q;
    hold_dest_d  = hold_dest_q;
    hold_stamp_d = hold_stamp_q;
    out_v_d      = out_v_q && !out_ready_i;
    out_kind_d   = out_kind_q;
    out_dest_d   = out_dest_q;
    out_stamp_d  = out_stamp_q;
    out_last_d   = out_last_q;

    if ((emit || cmd_i.flush) && hold_v_q) begin
      out_v_d     = 1'b1;
      out_kind_d  = hold_kind_q;
      out_dest_d  = hold_dest_q;
      out_stamp_d = hold_stamp_q;
      out_last_d  = cmd_i.flush;
      hold_v_d    = 1'b0;
    end

    if (emit) begin
      hold_v_d     = 1'b1;
      hold_kind_d  = e_kind;
      hold_dest_d  = e_dest;
      hold_stamp_d = clock_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_id_q <= '0;
      mask_q   <= '0;
      key_q    <= keys_for('0);
      def_q    <= '0;
      clock_q  <= '0;
      pend_q   <= '0;
      req_q    <= 1'b0;
      bump_q   <= 1'b0;
      cnt_q    <= '0;
      hold_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      if (cfg_we_i && (cfg_idx_i == REG_OWN_ID)) begin
        own_id_q <= cfg_data_i[ID_W-1:0];
      end
      if (cfg_we_i && (cfg_idx_i == REG_NBR_MASK)) begin
        mask_q <= cfg_data_i;
      end
      key_q    <= key_d;
      def_q    <= def_d;
      clock_q  <= clock_d;
      pend_q   <= pend_d;
      req_q    <= req_d;
      bump_q   <= bump_d;
      cnt_q    <= cnt_d;
      hold_v_q <= hold_v_d;
      out_v_q  <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      func_q <= in_func_i;
      sid_q  <= in_sid_i;
      ts_q   <= in_time_i;
    end
    hold_kind_q  <= hold_kind_d;
    hold_dest_q  <= hold_dest_d;
    hold_stamp_q <= hold_stamp_d;
    out_kind_q   <= out_kind_d;
    out_dest_q   <= out_dest_d;
    out_stamp_q  <= out_stamp_d;
    out_last_q   <= out_last_d;
  end

  assign out_valid_o = out_v_q;
  assign out_kind_o  = out_kind_q;
  assign out_dest_o  = out_dest_q;
  assign out_stamp_o = out_stamp_q;
  assign out_last_o  = out_last_q;

endmodule

FILE: hw/rtl/key_based_mutex_node.sv
// One node of key-per-neighbor mutual exclusion with a saturating Lamport clock.
// A received request takes the MSG step and maybe a REREQ step; a local request or a received key
// may run the datapath's scans, one neighbor a cycle unless the output stalls.
// One beat is in work at a time; a stalled output holds the scan back.
// Reset is asynchronous; keys come up held toward every higher id, nothing else pending.
`timescale 1ns / 1ps

`include "key_based_mutex_node_macros.svh"

module key_based_mutex_node #(
  parameter int unsigned MAX_NODES = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [kmx_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [kmx_pkg::MASK_W-1:0]       cfg_data_i,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [23:0]                      s_axis_tdata,  // sender_id[3:0], sender_time[19:4]
  input  logic [1:0]                       s_axis_tuser,  // func[1:0]
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [23:0]                      m_axis_tdata,  // dest_id[3:0], stamp[19:4]
  output logic [1:0]                       m_axis_tuser,  // kind[1:0]
  output logic                             m_axis_tlast
);
  import kmx_pkg::*;

  cmd_t              cmd;
  sts_t              sts;
  logic [ID_W-1:0]   out_dest;
  logic [TIME_W-1:0] out_stamp;
  logic              in_local;

  kmx_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_func_i  (s_axis_tuser),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  kmx_datapath #(
    .MAX_NODES (MAX_NODES)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_func_i   (s_axis_tuser),
    .in_sid_i    (s_axis_tdata[3:0]),
    .in_time_i   (s_axis_tdata[19:4]),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_kind_o  (m_axis_tuser),
    .out_dest_o  (out_dest),
    .out_stamp_o (out_stamp),
    .out_last_o  (m_axis_tlast)
  );

  assign m_axis_tdata = {4'b0000, out_stamp, out_dest};
  assign in_local     = s_axis_tvalid && s_axis_tready && (s_axis_tuser == FUNC_LOCAL);

  `KMX_ASSERT_IMP(a_idle_hold_empty, s_axis_tready, !sts.hold_v, "result left behind at idle")
  `KMX_ASSERT_NXT(a_local_sets_req, in_local, sts.requesting, "local request not recorded")
  `KMX_ASSERT_IMP(a_enter_has_keys, cmd.enter, sts.all_keys && sts.requesting, "entered without all keys")
  `KMX_ASSERT_IMP(a_one_step, 1'b1, $onehot0(cmd), "more than one step command")

endmodule

FILE: test/key_based_mutex_node_checker.sv
// Checker for the key-per-neighbor mutual exclusion node: predicts the result beats
// of every accepted input beat and compares them with the output stream.
// Depends on kmx_pkg for the function and kind codes and the register indexes.
`timescale 1ns / 1ps

module key_based_mutex_node_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [kmx_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [kmx_pkg::MASK_W-1:0]    cfg_data_i,
  input  logic                          s_axis_tvalid,
  input  logic                          s_axis_tready,
  input  logic [23:0]                   s_axis_tdata,  // sender_id[3:0], sender_time[19:4]
  input  logic [1:0]                    s_axis_tuser,  // func[1:0]
  input  logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  input  logic [23:0]                   m_axis_tdata,  // dest_id[3:0], stamp[19:4]
  input  logic [1:0]                    m_axis_tuser,  // kind[1:0]
  input  logic                          m_axis_tlast,
  output int unsigned                   fail_count_o,
  output int unsigned                   pending_o,
  output logic [15:0]                   lamport_o
);

  import kmx_pkg::*;

  localparam int unsigned MAX_BEATS = 16;

  typedef struct packed {
    logic [1:0]        kind;
    logic [ID_W-1:0]   dest;
    logic [TIME_W-1:0] stamp;
    logic              last;
  } msg_t;

  msg_t expected_beats[$];
  msg_t step_beats[$];

  logic [NUM_IDS-1:0] keys_held;
  logic [NUM_IDS-1:0] deferred;
  logic [TIME_W-1:0]  lamport;
  logic [TIME_W-1:0]  req_stamp;
  logic               requesting;
  logic [ID_W-1:0]    node_id;
  logic [MASK_W-1:0]  nbr_mask;
  int unsigned        errors = 0;

  assign fail_count_o = errors;

  function automatic bit is_nbr(int unsigned j);
    return (j != node_id) && nbr_mask[j];
  endfunction

  function automatic void reload_keys();
    for (int unsigned j = 0; j < NUM_IDS; j++) begin
      keys_held[j] = (node_id < j);
    end
    deferred = '0;
  endfunction

  function automatic void add_result(kind_e kind, logic [ID_W-1:0] dest);
    msg_t m;
    if (step_beats.size() >= MAX_BEATS) return;
    m.kind  = kind;
    m.dest  = dest;
    m.stamp = lamport;
    m.last  = 1'b0;
    step_beats.push_back(m);
  endfunction

  function automatic void hand_over(int unsigned j);
    if (keys_held[j]) begin
      keys_held[j] = 1'b0;
      add_result(KIND_KEY, ID_W'(j));
    end
  endfunction

  // Enter once every neighbor's key is here, then leave at once and serve the deferred.
  function automatic void try_enter();
    bit missing;
    missing = 1'b0;
    if (!requesting) return;
    for (int unsigned j = 0; j < NUM_IDS; j++) begin
      if (is_nbr(j) && !keys_held[j]) missing = 1'b1;
    end
    if (missing) return;
    add_result(KIND_ENTER, '0);
    requesting = 1'b0;
    for (int unsigned j = 0; j < NUM_IDS; j++) begin
      if (deferred[j]) begin
        deferred[j] = 1'b0;
        if (is_nbr(j)) hand_over(j);
      end
    end
  endfunction

  function automatic void predict_beat(logic [1:0] func, logic [ID_W-1:0] sid,
                                       logic [TIME_W-1:0] ts);
    bit asked;
    logic [TIME_W-1:0] bumped;
    msg_t m;
    asked = 1'b0;
    step_beats.delete();
    case (func)
      FUNC_LOCAL: begin
        if (!requesting) begin
          requesting = 1'b1;
          req_stamp  = lamport;
          for (int unsigned j = 0; j < NUM_IDS; j++) begin
            if (is_nbr(j) && !keys_held[j]) begin
              add_result(KIND_REQ, ID_W'(j));
              asked = 1'b1;
            end
          end
          if (!asked) try_enter();
          if (lamport != TIME_MAX) lamport = lamport + 1'b1;
        end
      end
      FUNC_REQ, FUNC_KEY: begin
        bumped  = (lamport == TIME_MAX) ? TIME_MAX : lamport + 1'b1;
        lamport = (bumped > ts) ? bumped : ts;
        if (is_nbr(sid)) begin
          if (func == FUNC_REQ) begin
            if (!requesting) begin
              hand_over(sid);
            end else if (ts < req_stamp || (ts == req_stamp && sid < node_id)) begin
              // The other request wins: give the key and ask for it back.
              if (keys_held[sid]) begin
                hand_over(sid);
                add_result(KIND_REQ, sid);
              end
            end else begin
              deferred[sid] = 1'b1;
            end
          end else begin
            keys_held[sid] = 1'b1;
            try_enter();
          end
        end
      end
      default: ;
    endcase
    if (step_beats.size() > 0) begin
      m = step_beats.pop_back();
      m.last = 1'b1;
      step_beats.push_back(m);
    end
    while (step_beats.size() > 0) expected_beats.push_back(step_beats.pop_front());
  endfunction

  function automatic void check_field(string what, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
    end
  endfunction

  function automatic void check_result();
    msg_t want;
    if (expected_beats.size() == 0) begin
      errors++;
      $display("%0t: result beat with none expected, actual kind %0d dest %0d stamp %0d last %0b",
               $time, m_axis_tuser, m_axis_tdata[3:0], m_axis_tdata[19:4], m_axis_tlast);
    end else begin
      want = expected_beats.pop_front();
      check_field("kind", 16'(want.kind), 16'(m_axis_tuser));
      check_field("dest_id", 16'(want.dest), 16'(m_axis_tdata[3:0]));
      check_field("stamp", want.stamp, m_axis_tdata[19:4]);
      check_field("last", 16'(want.last), 16'(m_axis_tlast));
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_id    = '0;
      nbr_mask   = '0;
      lamport    = '0;
      req_stamp  = '0;
      requesting = 1'b0;
      reload_keys();
      expected_beats.delete();
    end else begin
      // Outputs first: a result can never come from a beat taken at the same edge.
      if (m_axis_tvalid && m_axis_tready) check_result();
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_OWN_ID) begin
          node_id = cfg_data_i[ID_W-1:0];
          reload_keys();
        end else if (cfg_idx_i == REG_NBR_MASK) begin
          nbr_mask = cfg_data_i;
          reload_keys();
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        predict_beat(s_axis_tuser, s_axis_tdata[3:0], s_axis_tdata[19:4]);
      end
    end
    pending_o <= expected_beats.size();
    lamport_o <= lamport;
  end

endmodule

FILE: test/key_based_mutex_node_test.sv
// Testbench top for the mutual exclusion node: drives configuration and input beats,
// throttles the output side, and gives the verdict from key_based_mutex_node_checker.
// Depends on kmx_pkg, the checker module and the key_based_mutex_node RTL.
`timescale 1ns / 1ps

module key_based_mutex_node_test;

  import kmx_pkg::*;

  localparam logic [1:0]  FUNC_SPARE   = 2'd3;
  localparam int unsigned SCAN_CYCLES  = 48;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned PHASE_BEATS  = 40;
  localparam int unsigned NUM_PHASES   = 10;
  localparam int unsigned CYCLE_LIMIT  = 2000000;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [MASK_W-1:0]    cfg_data_i;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [23:0]          s_axis_tdata;
  logic [1:0]           s_axis_tuser;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [23:0]          m_axis_tdata;
  logic [1:0]           m_axis_tuser;
  logic                 m_axis_tlast;

  int unsigned fail_count;
  int unsigned pending;
  logic [15:0] lamport_now;

  logic [ID_W-1:0]   cur_id;
  logic [MASK_W-1:0] cur_mask;
  int unsigned       beats_sent;
  int unsigned       hold_asked;
  int unsigned       cycles;
  bit                steady;

  key_based_mutex_node dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  key_based_mutex_node_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .fail_count_o  (fail_count),
    .pending_o     (pending),
    .lamport_o     (lamport_now)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  function automatic int unsigned idle_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (steady || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [15:0] clamp_time(int t);
    if (t < 0) return '0;
    if (t > 65535) return TIME_MAX;
    return t[15:0];
  endfunction

  function automatic logic [15:0] near_time();
    int t;
    t = int'(lamport_now);
    t = t + $urandom_range(0, 9) - 4;
    return clamp_time(t);
  endfunction

  function automatic logic [15:0] sat_time();
    if ($urandom_range(0, 99) < 70) return TIME_MAX;
    return 16'($urandom_range(0, 65535));
  endfunction

  // Stamps around our own pending request reach wins, losses and ties.
  function automatic logic [15:0] req_time(logic [15:0] pend, bit sat);
    int t;
    if (sat) return sat_time();
    if ($urandom_range(0, 99) >= 75) return near_time();
    t = int'(pend);
    t = t + $urandom_range(0, 6) - 3;
    return clamp_time(t);
  endfunction

  function automatic logic [ID_W-1:0] pick_nbr();
    logic [ID_W-1:0] ids[$];
    for (int unsigned j = 0; j < NUM_IDS; j++) begin
      if (cur_mask[j] && j != cur_id) ids.push_back(ID_W'(j));
    end
    if (ids.size() == 0) return ID_W'($urandom_range(0, 15));
    return ids[$urandom_range(0, ids.size() - 1)];
  endfunction

  function automatic logic [MASK_W-1:0] sparse_mask();
    logic [MASK_W-1:0] m;
    int unsigned n;
    m = '0;
    n = $urandom_range(2, 4);
    for (int unsigned k = 0; k < n; k++) m[$urandom_range(0, 15)] = 1'b1;
    return m;
  endfunction

  task automatic send_beat(input logic [1:0] func, input logic [ID_W-1:0] sid,
                           input logic [15:0] ts);
    int unsigned gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= func;
    s_axis_tdata  <= {4'b0000, ts, sid};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    if (func != FUNC_SPARE) beats_sent++;
    gap = idle_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Stops offering beats and waits for every expected result; with tail set it also
  // lets a scan that makes no result run out.
  task automatic drain_results(input bit tail);
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    if (tail) repeat (SCAN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [MASK_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
  endtask

  task automatic set_node(input logic [ID_W-1:0] id, input logic [MASK_W-1:0] mask);
    drain_results(1'b1);
    write_reg(REG_OWN_ID, MASK_W'(id));
    write_reg(REG_NBR_MASK, mask);
    cfg_we_i <= 1'b0;
    cur_id   = id;
    cur_mask = mask;
  endtask

  // A local request followed by the keys of all neighbors in random order, with
  // neighbor requests mixed in; now and then one key is left out.
  task automatic run_session(input bit sat);
    logic [ID_W-1:0] order[$];
    logic [ID_W-1:0] tmp;
    logic [15:0]     pend;
    int unsigned     m;
    bit              drop;
    pend = lamport_now;
    drop = ($urandom_range(0, 99) < 10);
    send_beat(FUNC_LOCAL, ID_W'($urandom_range(0, 15)), sat ? sat_time() : near_time());
    for (int unsigned j = 0; j < NUM_IDS; j++) begin
      if (cur_mask[j] && j != cur_id) order.push_back(ID_W'(j));
    end
    for (int k = order.size() - 1; k > 0; k--) begin
      m        = $urandom_range(0, k);
      tmp      = order[k];
      order[k] = order[m];
      order[m] = tmp;
    end
    for (int k = 0; k < order.size(); k++) begin
      if ($urandom_range(0, 99) < 30) send_beat(FUNC_REQ, pick_nbr(), req_time(pend, sat));
      if (!(drop && k == 0)) send_beat(FUNC_KEY, order[k], sat ? sat_time() : near_time());
    end
  endtask

  task automatic noise_beat(input bit sat);
    logic [15:0] ts;
    if (sat) ts = sat_time();
    else if ($urandom_range(0, 99) < 4) ts = 16'($urandom_range(0, 65535));
    else ts = near_time();
    send_beat(2'($urandom_range(0, 3)), ID_W'($urandom_range(0, 15)), ts);
  endtask

  task automatic run_phase(input bit sat);
    int unsigned start;
    int unsigned r;
    start = beats_sent;
    while (beats_sent - start < PHASE_BEATS) begin
      r = $urandom_range(0, 99);
      if (r < 3) drain_results(1'b0);
      else if (r < 75) run_session(sat);
      else noise_beat(sat);
    end
  endtask

  // Output side: runs of ready and of stall, plus one long hold-off on request.
  initial begin
    int unsigned hold_seen;
    int unsigned run_left;
    int unsigned r;
    bit          level;
    hold_seen = 0;
    run_left  = 0;
    level     = 1'b0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_seen != hold_asked) begin
        hold_seen = hold_asked;
        level     = 1'b0;
        run_left  = HOLD_CYCLES;
      end else if (run_left == 0) begin
        r = $urandom_range(0, 99);
        if (steady || r < 80) begin
          level    = 1'b1;
          run_left = steady ? 1 : $urandom_range(1, 8);
        end else begin
          level    = 1'b0;
          run_left = (r < 96) ? $urandom_range(1, 3) : $urandom_range(10, 40);
        end
      end
      run_left--;
      m_axis_tready <= level;
    end
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("** key_based_mutex_node: FAILED **");
    $finish;
  end

  initial begin
    logic [15:0] pend;
    logic [ID_W-1:0] id;
    beats_sent = 0;
    hold_asked = 0;
    steady     = 1'b0;
    cur_id     = '0;
    cur_mask   = '0;
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= '0;
    cfg_data_i    <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: no neighbors, so a local request enters at once.
    send_beat(FUNC_LOCAL, 4'd0, 16'd0);
    send_beat(FUNC_REQ, 4'd3, 16'd0);
    send_beat(FUNC_SPARE, 4'd15, TIME_MAX);

    // Own bit set in the mask; keys are held toward ids above five.
    set_node(4'd5, 16'hFFFF);
    send_beat(FUNC_KEY, 4'd3, 16'd0);
    send_beat(FUNC_REQ, 4'd9, 16'd0);
    send_beat(FUNC_REQ, 4'd2, 16'd0);
    send_beat(FUNC_REQ, 4'd5, 16'd0);
    drain_results(1'b1);
    pend = lamport_now;
    send_beat(FUNC_LOCAL, 4'd0, 16'd0);
    send_beat(FUNC_LOCAL, 4'd0, 16'd0);
    // Equal stamps: the lower id wins against us, the higher id is deferred.
    send_beat(FUNC_REQ, 4'd4, pend);
    send_beat(FUNC_REQ, 4'd7, pend);
    send_beat(FUNC_REQ, 4'd6, 16'd0);
    send_beat(FUNC_REQ, 4'd15, pend + 16'd100);
    send_beat(FUNC_KEY, 4'd0, 16'd0);
    send_beat(FUNC_KEY, 4'd1, 16'd0);
    send_beat(FUNC_KEY, 4'd2, 16'd0);
    send_beat(FUNC_KEY, 4'd4, 16'd0);
    send_beat(FUNC_KEY, 4'd9, 16'd0);
    send_beat(FUNC_KEY, 4'd6, 16'd0);

    set_node(4'd0, 16'hFFFF);
    send_beat(FUNC_LOCAL, 4'd0, 16'd0);
    set_node(4'd15, 16'h0000);
    send_beat(FUNC_LOCAL, 4'd0, 16'd0);
    set_node(4'd15, 16'hFFFF);
    send_beat(FUNC_LOCAL, 4'd0, 16'd0);

    for (int unsigned p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: set_node(4'd15, 16'hFFFF);
        1: set_node(4'd0, 16'hFFFF);
        2: set_node(4'd9, 16'h0000);
        4, 6: set_node(ID_W'($urandom_range(0, 15)), sparse_mask());
        5: begin
          id = ID_W'($urandom_range(0, 15));
          set_node(id, sparse_mask() | (16'h0001 << id));
        end
        default: set_node(ID_W'($urandom_range(0, 15)), MASK_W'($urandom_range(0, 65535)));
      endcase
      steady = (p % 4 == 2);
      // The output side stalls long while beats keep coming, so the node backs up.
      if (p == 3) hold_asked++;
      run_phase(1'b0);
    end
    steady = 1'b0;

    // Last phase: the clock saturates, so ties at the top stamp are decided by id.
    set_node(ID_W'($urandom_range(0, 15)), sparse_mask());
    send_beat(FUNC_REQ, pick_nbr(), TIME_MAX);
    run_phase(1'b1);

    drain_results(1'b1);
    if (fail_count == 0 && pending == 0) begin
      $display("** key_based_mutex_node: PASSED **");
    end else begin
      $display("** key_based_mutex_node: FAILED **");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+hw/rtl
hw/rtl/kmx_pkg.sv
hw/rtl/kmx_ctrl.sv
hw/rtl/kmx_datapath.sv
hw/rtl/key_based_mutex_node.sv
test/key_based_mutex_node_checker.sv
test/key_based_mutex_node_test.sv
